// ----- sv/cts_pkg.sv -----
// ---------------------------------------------------------------------------
// cts_pkg: shared types and constants of the CAN timeout supervisor
// Table size, field widths, item and register codes, sequencer states and
// the per-entry runtime record passed to the entry update unit.
// ---------------------------------------------------------------------------
package cts_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int ID_W    = 29;
	localparam int TO_W    = 16;
	localparam int STEP_W  = 8;
	localparam int TICKS_W = 8;
	localparam int ACT_W   = 5;
	localparam int MASK_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		MODE_FRAME = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE  = 2'd0,
		REG_STEP    = 2'd1,
		REG_RECOVER = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// runtime record of one table entry
	typedef struct packed {
		logic [TO_W-1:0]    timer;
		logic [TICKS_W-1:0] ticks;
		logic               seen;
		logic               lost;
	} entry_state_t;

	// tick settings handed to the entry update unit
	typedef struct packed {
		logic               off;
		logic [STEP_W-1:0]  step;
		logic [TICKS_W-1:0] recover;
	} tick_ctrl_t;

	// map the per-entry flags onto the fixed-width result mask
	function automatic logic [MASK_W-1:0] to_mask(input logic [ENTRIES-1:0] v);
		logic [MASK_W-1:0] r;
		r = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < ENTRIES) begin
				r[i] = v[i];
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/cts_if.sv -----
// ---------------------------------------------------------------------------
// cts_if: channel interfaces of the CAN timeout supervisor
// Input item, result item and configuration write channels, each with
// valid/ready handshake and source/sink modports.
// ---------------------------------------------------------------------------
interface cts_item_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic [cts_pkg::ID_W-1:0] frame_id;
	logic                     supervision_off;
	logic [3:0]               entry_index;
	logic [cts_pkg::ID_W-1:0] entry_id;
	logic [cts_pkg::TO_W-1:0] entry_timeout_ms;

	modport source (output valid, mode, frame_id, supervision_off, entry_index,
		entry_id, entry_timeout_ms, input ready);
	modport sink (input valid, mode, frame_id, supervision_off, entry_index,
		entry_id, entry_timeout_ms, output ready);
endinterface

interface cts_result_if;
	logic                       valid;
	logic                       ready;
	logic [cts_pkg::MASK_W-1:0] lost_mask;
	logic [cts_pkg::MASK_W-1:0] changed_mask;
	logic                       matched;
	logic [3:0]                 matched_index;

	modport source (output valid, lost_mask, changed_mask, matched, matched_index,
		input ready);
	modport sink (input valid, lost_mask, changed_mask, matched, matched_index,
		output ready);
endinterface

interface cts_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cts_pkg::CFG_IDX_W-1:0]  index;
	logic [cts_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/can_timeout_supervisor_with_recovery.sv -----
// ---------------------------------------------------------------------------
// can_timeout_supervisor_with_recovery: CAN identifier loss supervisor
// Watches a table of identifiers for silence and reports lost entries.
// ---------------------------------------------------------------------------
// Channels: item (sink) takes frame, tick and table-write transactions;
// result (source) returns one transaction per item with the lost mask,
// the mask of entries whose lost state changed, and the frame match.
// cfg (sink) writes active_entries, tick_step_ms and recovery_count; it is
// always ready and must only be used while no item is in flight.
// Timing: a tick or frame item walks the table in the scan state, one active
// entry per cycle, through the single shared entry update unit, and ends on
// seeing the end of the scan; a frame stops at the first match, and a table
// write does not walk. The done state then loads the result register, and a
// new item is accepted the cycle after the previous result has been loaded.
// Stall: the result register holds while result.ready is low; a finished
// scan waits for the register to free, and item.ready stays low meanwhile.
// Reset: all timers, counts and flags clear at once; the identifier and
// timeout tables hold no valid content until written.
// ---------------------------------------------------------------------------
module can_timeout_supervisor_with_recovery (
	input  logic         clk,
	input  logic         arst_n,
	cts_item_if.sink     item,
	cts_result_if.source result,
	cts_cfg_if.sink      cfg
);

	localparam int E = cts_pkg::ENTRIES;

	// configuration
	logic [cts_pkg::ACT_W-1:0]   active_q;
	logic [cts_pkg::STEP_W-1:0]  step_q;
	logic [cts_pkg::TICKS_W-1:0] recover_q;

	// table storage and runtime state
	logic [cts_pkg::ID_W-1:0]    id_q      [E];
	logic [cts_pkg::TO_W-1:0]    timeout_q [E];
	logic [cts_pkg::TO_W-1:0]    timer_q   [E];
	logic [cts_pkg::TICKS_W-1:0] ticks_q   [E];
	logic [E-1:0]                seen_q;
	logic [E-1:0]                lost_q;

	// latched item
	cts_pkg::mode_t              mode_q;
	logic [cts_pkg::ID_W-1:0]    fid_q;
	logic                        off_q;
	logic [3:0]                  widx_q;
	logic [cts_pkg::ID_W-1:0]    wid_q;
	logic [cts_pkg::TO_W-1:0]    wto_q;

	// sequencer and accumulated result
	cts_pkg::state_t             state_q, state_d;
	logic [cts_pkg::CNT_W-1:0]   cnt_q;
	logic [E-1:0]                changed_q;
	logic                        matched_q;
	logic [3:0]                  midx_q;

	// result register
	logic                        out_valid_q;
	logic [cts_pkg::MASK_W-1:0]  out_lost_q;
	logic [cts_pkg::MASK_W-1:0]  out_changed_q;
	logic                        out_matched_q;
	logic [3:0]                  out_midx_q;

	logic                        item_acc;
	logic                        out_free;
	logic                        load_out;
	logic [cts_pkg::CNT_W-1:0]   n_active;
	logic                        scan_end;
	logic [cts_pkg::IDX_W-1:0]   cur;
	logic [cts_pkg::IDX_W-1:0]   waddr;
	logic                        wvalid;
	logic                        id_hit;
	cts_pkg::entry_state_t       ent_cur, ent_nxt;
	cts_pkg::tick_ctrl_t         tick_ctrl;
	logic                        ent_changed;

	assign item.ready = state_q == cts_pkg::ST_IDLE;
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign out_free   = !out_valid_q || result.ready;
	assign load_out   = (state_q == cts_pkg::ST_DONE) && out_free;

	// cap the active count at the table size
	always_comb begin
		if (32'(active_q) > 32'(E)) begin
			n_active = cts_pkg::CNT_W'(E);
		end else begin
			n_active = cts_pkg::CNT_W'(active_q);
		end
	end

	assign scan_end = cnt_q >= n_active;
	assign cur      = cnt_q[cts_pkg::IDX_W-1:0];
	assign waddr    = cts_pkg::IDX_W'(widx_q);
	assign wvalid   = 32'(widx_q) < 32'(E);
	assign id_hit   = id_q[cur] == fid_q;

	// present the current entry to the shared update unit
	assign ent_cur.timer = timer_q[cur];
	assign ent_cur.ticks = ticks_q[cur];
	assign ent_cur.seen  = seen_q[cur];
	assign ent_cur.lost  = lost_q[cur];
	assign tick_ctrl.off     = off_q;
	assign tick_ctrl.step    = step_q;
	assign tick_ctrl.recover = recover_q;

	cts_entry_unit u_entry (
		.cur          (ent_cur),
		.timeout      (timeout_q[cur]),
		.ctrl         (tick_ctrl),
		.nxt          (ent_nxt),
		.lost_changed (ent_changed)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cts_pkg::ST_IDLE: begin
				if (item_acc) begin
					state_d = cts_pkg::ST_RUN;
				end
			end
			cts_pkg::ST_RUN: begin
				unique case (mode_q)
					cts_pkg::MODE_FRAME: begin
						if (scan_end || id_hit) begin
							state_d = cts_pkg::ST_DONE;
						end
					end
					cts_pkg::MODE_TICK: begin
						if (scan_end) begin
							state_d = cts_pkg::ST_DONE;
						end
					end
					default: begin
						state_d = cts_pkg::ST_DONE;
					end
				endcase
			end
			cts_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = cts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cts_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			step_q    <= cts_pkg::STEP_W'(10);
			recover_q <= cts_pkg::TICKS_W'(3);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cts_pkg::reg_idx_t'(cfg.index))
				cts_pkg::REG_ACTIVE:  active_q  <= cfg.data[cts_pkg::ACT_W-1:0];
				cts_pkg::REG_STEP:    step_q    <= cfg.data;
				cts_pkg::REG_RECOVER: recover_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (item_acc) begin
			mode_q <= cts_pkg::mode_t'(item.mode);
			fid_q  <= item.frame_id;
			off_q  <= item.supervision_off;
			widx_q <= item.entry_index;
			wid_q  <= item.entry_id;
			wto_q  <= item.entry_timeout_ms;
		end
	end

	// identifier and timeout tables: loaded by table writes only
	always_ff @(posedge clk) begin
		if (state_q == cts_pkg::ST_RUN && mode_q == cts_pkg::MODE_WRITE && wvalid) begin
			id_q[waddr]      <= wid_q;
			timeout_q[waddr] <= wto_q;
		end
	end

	// runtime state and result accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < E; i++) begin
				timer_q[i] <= '0;
				ticks_q[i] <= '0;
			end
			seen_q    <= '0;
			lost_q    <= '0;
			cnt_q     <= '0;
			changed_q <= '0;
			matched_q <= 1'b0;
			midx_q    <= '0;
		end else if (item_acc) begin
			cnt_q     <= '0;
			changed_q <= '0;
			matched_q <= 1'b0;
			midx_q    <= '0;
		end else if (state_q == cts_pkg::ST_RUN) begin
			unique case (mode_q)
				cts_pkg::MODE_FRAME: begin
					// mark the first matching entry as seen
					if (!scan_end) begin
						if (id_hit) begin
							seen_q[cur] <= 1'b1;
							matched_q   <= 1'b1;
							midx_q      <= 4'(cur);
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				cts_pkg::MODE_TICK: begin
					// write back one entry per cycle
					if (!scan_end) begin
						timer_q[cur]   <= ent_nxt.timer;
						ticks_q[cur]   <= ent_nxt.ticks;
						seen_q[cur]    <= ent_nxt.seen;
						lost_q[cur]    <= ent_nxt.lost;
						changed_q[cur] <= ent_changed;
						cnt_q          <= cnt_q + 1'b1;
					end
				end
				cts_pkg::MODE_WRITE: begin
					// clear runtime state of the written entry
					if (wvalid) begin
						timer_q[waddr]   <= '0;
						ticks_q[waddr]   <= '0;
						seen_q[waddr]    <= 1'b0;
						lost_q[waddr]    <= 1'b0;
						changed_q[waddr] <= lost_q[waddr];
					end
				end
				default: ;
			endcase
		end
	end

	// result register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_lost_q    <= cts_pkg::to_mask(lost_q);
			out_changed_q <= cts_pkg::to_mask(changed_q);
			out_matched_q <= matched_q;
			out_midx_q    <= midx_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.lost_mask     = out_lost_q;
	assign result.changed_mask  = out_changed_q;
	assign result.matched       = out_matched_q;
	assign result.matched_index = out_midx_q;

endmodule

// ----- sv/cts_entry_unit.sv -----
// ---------------------------------------------------------------------------
// cts_entry_unit: tick update of one supervised entry
// Shared by all entries; the sequencer presents one entry per cycle and
// writes back the next runtime record.
// ---------------------------------------------------------------------------
module cts_entry_unit (
	input  cts_pkg::entry_state_t      cur,
	input  logic [cts_pkg::TO_W-1:0]   timeout,
	input  cts_pkg::tick_ctrl_t        ctrl,
	output cts_pkg::entry_state_t      nxt,
	output logic                       lost_changed
);

	logic [cts_pkg::TO_W:0]      sum;
	logic [cts_pkg::TICKS_W-1:0] ticks_inc;

	// saturating timer advance and seen count
	assign sum = {1'b0, cur.timer} + {{(cts_pkg::TO_W + 1 - cts_pkg::STEP_W){1'b0}}, ctrl.step};
	assign ticks_inc = (&cur.ticks) ? cur.ticks : cur.ticks + 1'b1;

	always_comb begin
		nxt = cur;
		priority if (ctrl.off) begin
			// supervision forbidden: clear and recover
			nxt.timer = '0;
			nxt.ticks = '0;
			nxt.seen  = 1'b0;
			nxt.lost  = 1'b0;
		end else if (cur.seen) begin
			// traffic seen: restart timer, count toward recovery
			nxt.timer = '0;
			nxt.seen  = 1'b0;
			if (cur.lost) begin
				nxt.ticks = ticks_inc;
				if (ticks_inc > ctrl.recover) begin
					nxt.lost = 1'b0;
				end
			end
		end else if (!cur.lost) begin
			// silence: declare loss at timeout, else advance
			if (cur.timer >= timeout) begin
				nxt.ticks = '0;
				nxt.lost  = 1'b1;
			end else begin
				nxt.timer = sum[cts_pkg::TO_W] ? {cts_pkg::TO_W{1'b1}} : sum[cts_pkg::TO_W-1:0];
			end
		end
	end

	assign lost_changed = nxt.lost != cur.lost;

endmodule

// ----- tb/can_timeout_supervisor_with_recovery_tb.sv -----
// ---------------------------------------------------------------------------
// can_timeout_supervisor_with_recovery_tb: self-checking bench of the supervisor
// Runs a short table of directed items and then randomized phases under
// several register settings. It finishes with a long soak that drives one
// timer into saturation and one seen count up to its ceiling. Every result
// is checked field by field, against a local model of the table or, for the
// first directed items, against a fixed report. Both channels idle in random
// bursts, and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module can_timeout_supervisor_with_recovery_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	typedef struct packed {
		mode_t             mode;
		logic [ID_W-1:0]   frame_id;
		logic              off;
		logic [3:0]        entry_index;
		logic [ID_W-1:0]   entry_id;
		logic [TO_W-1:0]   timeout_ms;
	} can_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] lost_mask;
		logic [MASK_W-1:0] changed_mask;
		logic              matched;
		logic [3:0]        matched_index;
	} verdict_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		reg_idx_t              reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		can_item_t             stim;
		logic                  typed;
		verdict_t              want;
	} drill_row_t;

	localparam logic [ID_W-1:0] ID_MAX  = '1;
	localparam logic [TO_W-1:0] TO_MAX  = '1;
	localparam can_item_t       NO_STIM = '0;
	localparam verdict_t        NIL     = '0;
	localparam int              DRILL_N = 23;

	logic clk;
	logic arst_n;

	cts_item_if   item_ch ();
	cts_result_if res_ch ();
	cts_cfg_if    cfg_ch ();

	can_timeout_supervisor_with_recovery i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// local copy of the supervised table and the registers
	logic [ID_W-1:0]    watch_id   [ENTRIES];
	logic [TO_W-1:0]    watch_to   [ENTRIES];
	logic [TO_W-1:0]    silence    [ENTRIES];
	logic [TICKS_W-1:0] seen_cnt   [ENTRIES];
	logic [ENTRIES-1:0] seen_now;
	logic [ENTRIES-1:0] lost_now;
	logic [ACT_W-1:0]   act_entries;
	logic [STEP_W-1:0]  step_ms;
	logic [TICKS_W-1:0] recover_cnt;

	verdict_t owed_reports [$];

	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int match_seen   = 0;
	int lost_seen    = 0;
	int recov_seen   = 0;
	bit calm         = 1'b0;
	bit tx_gappy     = 1'b1;

	// free-running clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// apply one item to the local table and return the report it causes
	function automatic verdict_t supervise(input can_item_t it);
		verdict_t           v;
		logic [ENTRIES-1:0] flips;
		logic [TO_W:0]      sum;
		int unsigned        n;
		v = '0;
		flips = '0;
		n = (act_entries > ENTRIES) ? ENTRIES : act_entries;
		case (it.mode)
			MODE_FRAME: begin
				// first active entry with an equal identifier wins
				for (int i = 0; i < n; i++) begin
					if (!v.matched && watch_id[i] == it.frame_id) begin
						seen_now[i] = 1'b1;
						v.matched = 1'b1;
						v.matched_index = 4'(i);
					end
				end
			end
			MODE_TICK: begin
				for (int i = 0; i < n; i++) begin
					if (it.off) begin
						silence[i] = '0;
						seen_cnt[i] = '0;
						seen_now[i] = 1'b0;
						if (lost_now[i]) flips[i] = 1'b1;
						lost_now[i] = 1'b0;
					end else if (seen_now[i]) begin
						silence[i] = '0;
						seen_now[i] = 1'b0;
						if (lost_now[i]) begin
							if (seen_cnt[i] != '1) seen_cnt[i] = seen_cnt[i] + 1'b1;
							if (seen_cnt[i] > recover_cnt) begin
								lost_now[i] = 1'b0;
								flips[i] = 1'b1;
							end
						end
					end else if (!lost_now[i]) begin
						if (silence[i] >= watch_to[i]) begin
							seen_cnt[i] = '0;
							lost_now[i] = 1'b1;
							flips[i] = 1'b1;
						end else begin
							// advance the timer, saturating at full scale
							sum = (TO_W + 1)'(silence[i]) + (TO_W + 1)'(step_ms);
							silence[i] = sum[TO_W] ? TO_MAX : sum[TO_W-1:0];
						end
					end
				end
			end
			MODE_WRITE: begin
				watch_id[it.entry_index] = it.entry_id;
				watch_to[it.entry_index] = it.timeout_ms;
				silence[it.entry_index] = '0;
				seen_cnt[it.entry_index] = '0;
				seen_now[it.entry_index] = 1'b0;
				if (lost_now[it.entry_index]) flips[it.entry_index] = 1'b1;
				lost_now[it.entry_index] = 1'b0;
			end
			default: begin
			end
		endcase
		v.lost_mask = lost_now;
		v.changed_mask = flips;
		return v;
	endfunction

	// present one item, wait for its transaction, then maybe idle
	task automatic offer(input can_item_t it, input bit typed, input verdict_t want);
		verdict_t predicted;
		int       gap;
		item_ch.valid <= 1'b1;
		item_ch.mode <= it.mode;
		item_ch.frame_id <= it.frame_id;
		item_ch.supervision_off <= it.off;
		item_ch.entry_index <= it.entry_index;
		item_ch.entry_id <= it.entry_id;
		item_ch.entry_timeout_ms <= it.timeout_ms;
		do begin
			@(posedge clk);
		end while (item_ch.ready !== 1'b1);
		predicted = supervise(it);
		owed_reports.push_back(typed ? want : predicted);
		items_sent++;
		if (items_sent % 40 == 0) tx_gappy = ($urandom_range(0, 2) != 0);
		gap = 0;
		if (!calm && tx_gappy && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 10);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// write one register once the block has drained
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		item_ch.valid <= 1'b0;
		while (owed_reports.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do begin
			@(posedge clk);
		end while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_ACTIVE:  act_entries = val[ACT_W-1:0];
			REG_STEP:    step_ms = val;
			REG_RECOVER: recover_cnt = val;
			default: begin
			end
		endcase
	endtask

	// result side: check each transaction, stall in bursts, hold off once
	initial begin : result_sink
		verdict_t exp;
		int       stall_left;
		int       hold_left;
		int       cycles;
		bit       held;
		bit       rx_gappy;
		stall_left = 0;
		hold_left = 0;
		cycles = 0;
		held = 1'b0;
		rx_gappy = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				results_seen++;
				if (owed_reports.size() == 0) begin
					$error("result transaction with no item outstanding");
					errors++;
				end else begin
					exp = owed_reports.pop_front();
					if (res_ch.lost_mask !== exp.lost_mask) begin
						$error("lost_mask: expected %h, got %h", exp.lost_mask, res_ch.lost_mask);
						errors++;
					end
					if (res_ch.changed_mask !== exp.changed_mask) begin
						$error("changed_mask: expected %h, got %h", exp.changed_mask,
							res_ch.changed_mask);
						errors++;
					end
					if (res_ch.matched !== exp.matched) begin
						$error("matched: expected %0d, got %0d", exp.matched, res_ch.matched);
						errors++;
					end
					if (res_ch.matched_index !== exp.matched_index) begin
						$error("matched_index: expected %0d, got %0d", exp.matched_index,
							res_ch.matched_index);
						errors++;
					end
					if (exp.matched) match_seen++;
					lost_seen += $countones(exp.changed_mask & exp.lost_mask);
					recov_seen += $countones(exp.changed_mask & ~exp.lost_mask);
				end
			end
			cycles++;
			if (cycles % 150 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
			// one long hold-off so the block backs up into the item channel
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!calm && rx_gappy && $urandom_range(0, 99) < 8) begin
				stall_left = $urandom_range(1, 10) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus: reset, directed table, table load, random phases, soak
	initial begin : stimulus
		drill_row_t drill [DRILL_N];
		can_item_t  it;
		int         ph_act  [7];
		int         ph_step [7];
		int         ph_rec  [7];
		int         p;
		int         k;
		int         r;
		int unsigned n;
		logic [ID_W-1:0] soak_id;

		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= '0;
		item_ch.frame_id <= '0;
		item_ch.supervision_off <= 1'b0;
		item_ch.entry_index <= '0;
		item_ch.entry_id <= '0;
		item_ch.entry_timeout_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_ACTIVE;
		cfg_ch.data <= '0;
		for (k = 0; k < ENTRIES; k++) begin
			watch_id[k] = '0;
			watch_to[k] = '0;
			silence[k] = '0;
			seen_cnt[k] = '0;
		end
		seen_now = '0;
		lost_now = '0;
		act_entries = '0;
		step_ms = 8'd10;
		recover_cnt = 8'd3;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, edge fields, duplicate ids, loss, recovery paths
		drill = '{
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_NONE, ID_MAX, 1'b1, 4'hF, ID_MAX, TO_MAX}, 1'b1, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_FRAME, ID_MAX, 1'b0, 4'h0, '0, '0}, 1'b1, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b1, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_WRITE, '0, 1'b0, 4'h0, '0, '0}, 1'b1, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_WRITE, '0, 1'b0, 4'hF, ID_MAX, TO_MAX}, 1'b1, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_WRITE, '0, 1'b0, 4'h1, ID_MAX, 16'd20}, 1'b1, NIL},
			'{ROW_REG, REG_ACTIVE, 8'd2, NO_STIM, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_FRAME, ID_MAX, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_FRAME, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_WRITE, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_NONE, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_REG, REG_STEP, 8'd0, NO_STIM, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b1, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_REG, REG_STEP, 8'd255, NO_STIM, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_FRAME, 29'h0ABCDEF, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_REG, REG_RECOVER, 8'd0, NO_STIM, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_FRAME, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL},
			'{ROW_ITEM, REG_ACTIVE, 8'd0, '{MODE_TICK, '0, 1'b0, 4'h0, '0, '0}, 1'b0, NIL}
		};
		for (k = 0; k < DRILL_N; k++) begin
			if (drill[k].kind == ROW_REG) begin
				write_reg(drill[k].reg_idx, drill[k].reg_val);
			end else begin
				offer(drill[k].stim, drill[k].typed, drill[k].want);
			end
		end

		// load every entry so any active count reads written entries only
		for (k = 0; k < ENTRIES; k++) begin
			it.mode = MODE_WRITE;
			it.frame_id = ID_W'($urandom);
			it.off = 1'($urandom);
			it.entry_index = 4'(k);
			it.entry_id = (k % 4 == 3) ? watch_id[k - 2] : 29'($urandom);
			it.timeout_ms = TO_W'($urandom_range(0, 1500));
			offer(it, 1'b0, NIL);
		end

		// random phases, each under its own register setting
		ph_act = '{16, 31, 5, 12, 0, 16, 0};
		ph_step = '{10, 255, 1, 0, 77, 3, 0};
		ph_rec = '{3, 0, 254, 1, 2, 0, 0};
		for (p = 0; p < 7; p++) begin
			if (p == 6) begin
				ph_act[p] = $urandom_range(0, 31);
				ph_step[p] = $urandom_range(0, 255);
				ph_rec[p] = $urandom_range(0, 8);
			end
			write_reg(REG_ACTIVE, CFG_DATA_W'(ph_act[p]));
			write_reg(REG_STEP, CFG_DATA_W'(ph_step[p]));
			write_reg(REG_RECOVER, CFG_DATA_W'(ph_rec[p]));
			n = (act_entries > ENTRIES) ? ENTRIES : act_entries;
			for (k = 0; k < 60; k++) begin
				it.frame_id = ID_W'($urandom);
				it.off = 1'($urandom);
				it.entry_index = 4'($urandom);
				it.entry_id = ID_W'($urandom);
				it.timeout_ms = TO_W'($urandom);
				r = $urandom_range(0, 99);
				if (r < 40) begin
					// mostly identifiers that are in the table
					it.mode = MODE_FRAME;
					if (n != 0 && $urandom_range(0, 3) != 0)
						it.frame_id = watch_id[4'($urandom_range(0, n - 1))];
				end else if (r < 80) begin
					it.mode = MODE_TICK;
					it.off = ($urandom_range(0, 99) < 8);
				end else if (r < 94) begin
					// short timeouts in units of the step, some duplicate ids
					it.mode = MODE_WRITE;
					if ($urandom_range(0, 3) != 0)
						it.timeout_ms = 16'(step_ms * $urandom_range(0, 6));
					if ($urandom_range(0, 3) == 0)
						it.entry_id = watch_id[4'($urandom_range(0, ENTRIES - 1))];
				end else begin
					it.mode = MODE_NONE;
				end
				offer(it, 1'b0, NIL);
			end
		end

		// soak: entry 0 silent until its timer saturates and it is lost,
		// entry 1 lost and seen every tick until its count tops out
		write_reg(REG_ACTIVE, 8'd2);
		write_reg(REG_STEP, 8'd254);
		write_reg(REG_RECOVER, 8'd255);
		soak_id = ID_W'($urandom);
		it = '0;
		it.mode = MODE_WRITE;
		it.entry_index = 4'd0;
		it.entry_id = soak_id ^ 29'd1;
		it.timeout_ms = TO_MAX;
		offer(it, 1'b0, NIL);
		it.entry_index = 4'd1;
		it.entry_id = soak_id;
		it.timeout_ms = '0;
		offer(it, 1'b0, NIL);
		it.mode = MODE_TICK;
		offer(it, 1'b0, NIL);
		for (k = 0; k < 262; k++) begin
			calm = (k >= 200);
			it.mode = MODE_FRAME;
			it.frame_id = soak_id;
			offer(it, 1'b0, NIL);
			it.mode = MODE_TICK;
			offer(it, 1'b0, NIL);
		end
		// a saturated count must now exceed the lowered threshold
		write_reg(REG_RECOVER, 8'd254);
		it.mode = MODE_FRAME;
		offer(it, 1'b0, NIL);
		it.mode = MODE_TICK;
		offer(it, 1'b0, NIL);

		// drain, then watch for stray results
		item_ch.valid <= 1'b0;
		while (owed_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d items and %0d results: %0d frame matches, %0d losses, %0d recoveries",
			items_sent, results_seen, match_seen, lost_seen, recov_seen);
		$display("settings swept active 0..31, step 0..255, recovery 0..255; saturation soaked");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// abort a hung run
	initial begin : watchdog
		#2_000_000;
		$display("timeout: %0d results still outstanding", owed_reports.size());
		$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/cts_pkg.sv
sv/cts_if.sv
sv/cts_entry_unit.sv
sv/can_timeout_supervisor_with_recovery.sv
tb/can_timeout_supervisor_with_recovery_tb.sv
